// ===== hw/rtl/ffrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ffrs_pkg
// Types, character constants and match helpers for the FEAT reply scanner.
// ----------------------------------------------------------------------------
package ffrs_pkg;

  localparam int unsigned NumWords = 7;
  localparam int unsigned RestIndex = 5;
  localparam int unsigned MaskW = 6;

  typedef logic [7:0] byte_t;
  typedef logic [NumWords-1:0] cand_t;
  typedef logic [MaskW-1:0] mask_t;

  typedef enum logic [2:0] {
    PH_LEAD     = 3'd0,
    PH_CODE     = 3'd1,
    PH_POSTCODE = 3'd2,
    PH_WORD     = 3'd3,
    PH_RESTGAP  = 3'd4,
    PH_STREAM   = 3'd5,
    PH_DEAD     = 3'd6,
    PH_ENDED    = 3'd7
  } phase_t;

  localparam byte_t ChNul   = 8'h00;
  localparam byte_t ChTab   = 8'h09;
  localparam byte_t ChLf    = 8'h0A;
  localparam byte_t ChCr    = 8'h0D;
  localparam byte_t ChSpace = 8'h20;
  localparam byte_t ChDash  = 8'h2D;
  localparam byte_t ChSemi  = 8'h3B;

  localparam cand_t AllAlive = '1;

  localparam byte_t WORD_TEXT [NumWords][4] = '{
    '{"M", "L", "S", "T"},
    '{"M", "L", "S", "D"},
    '{"E", "P", "S", "V"},
    '{"S", "I", "Z", "E"},
    '{"M", "D", "T", "M"},
    '{"R", "E", "S", "T"},
    '{"U", "T", "F", "8"}
  };

  localparam byte_t STREAM_TEXT [6] = '{"S", "T", "R", "E", "A", "M"};

  // One beat of the input channel as it moves between modules.
  typedef struct packed {
    byte_t ch;
    logic  last_byte;
  } beat_t;

  // Result of one processed beat.
  typedef struct packed {
    logic  valid;
    mask_t mask;
  } result_t;

  function automatic logic is_blank(byte_t c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic is_digit(byte_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_eol(byte_t c);
    return (c == ChCr) || (c == ChLf);
  endfunction

  function automatic logic is_token_end(byte_t c);
    return (c == ChNul) || is_eol(c) || is_blank(c) || (c == ChSemi);
  endfunction

  function automatic byte_t fold_upper(byte_t c);
    return ((c >= "a") && (c <= "z")) ? byte_t'(c - 8'd32) : c;
  endfunction

  // Keeps each live candidate whose character at position p equals u.
  function automatic cand_t match_words(cand_t cand, logic [1:0] p, byte_t u);
    cand_t alive;
    alive = '0;
    for (int k = 0; k < NumWords; k++) begin
      alive[k] = cand[k] && (WORD_TEXT[k][p] == u);
    end
    return alive;
  endfunction

  // Capability bits for a token that is complete at its end character.
  function automatic mask_t close_caps(phase_t ph, logic [2:0] pos, cand_t cand);
    mask_t m;
    m = '0;
    if (ph == PH_WORD && pos == 3'd4) begin
      m[0] = cand[0] | cand[1];
      m[1] = cand[2];
      m[2] = cand[3];
      m[3] = cand[4];
      m[5] = cand[6];
    end else if (ph == PH_STREAM && pos == 3'd6) begin
      m[4] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/ffrs_if.sv =====
// ----------------------------------------------------------------------------
// ffrs_in_if / ffrs_out_if
// Valid/ready channels for reply bytes and capability masks.
// ----------------------------------------------------------------------------
interface ffrs_in_if;
  logic              valid;
  logic              ready;
  ffrs_pkg::byte_t   ch;
  logic              last_byte;

  modport source (output valid, output ch, output last_byte, input ready);
  modport sink   (input valid, input ch, input last_byte, output ready);
endinterface

interface ffrs_out_if;
  logic              valid;
  logic              ready;
  ffrs_pkg::mask_t   caps_mask;

  modport source (output valid, output caps_mask, input ready);
  modport sink   (input valid, input caps_mask, output ready);
endinterface

// ===== hw/rtl/ffrs_core.sv =====
// ----------------------------------------------------------------------------
// ffrs_core
// Per-line scanner state and the one-byte update of the capability matcher.
// ----------------------------------------------------------------------------
module ffrs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ffrs_pkg::beat_t   beat,
  output ffrs_pkg::result_t res
);

  ffrs_pkg::phase_t ph_r, ph_upd, ph_nxt;
  logic [1:0]       dc_r, dc_upd, dc_nxt;
  logic [2:0]       pos_r, pos_upd, pos_nxt;
  ffrs_pkg::cand_t  cand_r, cand_upd, cand_nxt;
  ffrs_pkg::mask_t  acc_r, acc_upd, acc_nxt;

  ffrs_pkg::byte_t  c;
  ffrs_pkg::byte_t  u;
  ffrs_pkg::cand_t  alive;
  ffrs_pkg::cand_t  first_alive;

  assign c           = beat.ch;
  assign u           = ffrs_pkg::fold_upper(beat.ch);
  assign alive       = ffrs_pkg::match_words(cand_r, pos_r[1:0], u);
  assign first_alive = ffrs_pkg::match_words(ffrs_pkg::AllAlive, 2'd0, u);

  // Next state: the byte update, then the return to reset after a last byte.
  always_comb begin
    ph_upd   = ph_r;
    dc_upd   = dc_r;
    pos_upd  = pos_r;
    cand_upd = cand_r;
    acc_upd  = acc_r;

    if (step && ph_r != ffrs_pkg::PH_ENDED) begin
      if (c == ffrs_pkg::ChNul) begin
        acc_upd = acc_r | ffrs_pkg::close_caps(ph_r, pos_r, cand_r);
        ph_upd  = ffrs_pkg::PH_ENDED;
      end else if (ffrs_pkg::is_eol(c)) begin
        acc_upd  = acc_r | ffrs_pkg::close_caps(ph_r, pos_r, cand_r);
        ph_upd   = ffrs_pkg::PH_LEAD;
        dc_upd   = 2'd0;
        pos_upd  = 3'd0;
        cand_upd = ffrs_pkg::AllAlive;
      end else begin
        unique case (ph_r)
          ffrs_pkg::PH_LEAD, ffrs_pkg::PH_POSTCODE: begin
            if (!ffrs_pkg::is_blank(c)) begin
              if (ph_r == ffrs_pkg::PH_LEAD && ffrs_pkg::is_digit(c)) begin
                ph_upd = ffrs_pkg::PH_CODE;
                dc_upd = 2'd1;
              end else if (first_alive == '0) begin
                ph_upd = ffrs_pkg::PH_DEAD;
              end else begin
                ph_upd   = ffrs_pkg::PH_WORD;
                pos_upd  = 3'd1;
                cand_upd = first_alive;
              end
            end
          end
          ffrs_pkg::PH_CODE: begin
            if (dc_r != 2'd3) begin
              if (ffrs_pkg::is_digit(c)) dc_upd = dc_r + 2'd1;
              else ph_upd = ffrs_pkg::PH_DEAD;
            end else if (c == ffrs_pkg::ChDash || c == ffrs_pkg::ChSpace) begin
              ph_upd = ffrs_pkg::PH_POSTCODE;
            end else begin
              ph_upd = ffrs_pkg::PH_DEAD;
            end
          end
          ffrs_pkg::PH_WORD: begin
            if (pos_r < 3'd4) begin
              cand_upd = alive;
              if (alive == '0) ph_upd = ffrs_pkg::PH_DEAD;
              else pos_upd = pos_r + 3'd1;
            end else if (ffrs_pkg::is_token_end(c)) begin
              acc_upd = acc_r | ffrs_pkg::close_caps(ph_r, pos_r, cand_r);
              // Only REST may continue into a second token.
              if (ffrs_pkg::is_blank(c) && cand_r[ffrs_pkg::RestIndex])
                ph_upd = ffrs_pkg::PH_RESTGAP;
              else
                ph_upd = ffrs_pkg::PH_DEAD;
            end else begin
              ph_upd = ffrs_pkg::PH_DEAD;
            end
          end
          ffrs_pkg::PH_RESTGAP: begin
            if (!ffrs_pkg::is_blank(c)) begin
              if (u == ffrs_pkg::STREAM_TEXT[0]) begin
                ph_upd  = ffrs_pkg::PH_STREAM;
                pos_upd = 3'd1;
              end else begin
                ph_upd  = ffrs_pkg::PH_DEAD;
                pos_upd = 3'd0;
              end
            end
          end
          ffrs_pkg::PH_STREAM: begin
            if (pos_r < 3'd6) begin
              if (u == ffrs_pkg::STREAM_TEXT[pos_r]) pos_upd = pos_r + 3'd1;
              else ph_upd = ffrs_pkg::PH_DEAD;
            end else begin
              if (ffrs_pkg::is_token_end(c))
                acc_upd = acc_r | ffrs_pkg::close_caps(ph_r, pos_r, cand_r);
              ph_upd = ffrs_pkg::PH_DEAD;
            end
          end
          default: begin
          end
        endcase
      end
    end

    ph_nxt   = ph_upd;
    dc_nxt   = dc_upd;
    pos_nxt  = pos_upd;
    cand_nxt = cand_upd;
    acc_nxt  = acc_upd;
    if (step && beat.last_byte) begin
      ph_nxt   = ffrs_pkg::PH_LEAD;
      dc_nxt   = 2'd0;
      pos_nxt  = 3'd0;
      cand_nxt = ffrs_pkg::AllAlive;
      acc_nxt  = '0;
    end
  end

  // A token still open at the final byte is closed as if by a string end.
  always_comb begin
    res = '0;
    if (step && beat.last_byte) begin
      res.valid = 1'b1;
      res.mask  = acc_upd;
      if (ph_upd != ffrs_pkg::PH_ENDED)
        res.mask = acc_upd | ffrs_pkg::close_caps(ph_upd, pos_upd, cand_upd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= ffrs_pkg::PH_LEAD;
      dc_r   <= 2'd0;
      pos_r  <= 3'd0;
      cand_r <= ffrs_pkg::AllAlive;
      acc_r  <= '0;
    end else begin
      ph_r   <= ph_nxt;
      dc_r   <= dc_nxt;
      pos_r  <= pos_nxt;
      cand_r <= cand_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ===== hw/rtl/ftp_feature_reply_scanner.sv =====
// ----------------------------------------------------------------------------
// ftp_feature_reply_scanner
// Scans the bytes of a multi-line FEAT reply and reports a capability mask.
// ----------------------------------------------------------------------------
// in_bus carries one reply byte per beat (ch, last_byte). out_bus carries one
// caps_mask beat per reply, produced by the beat that has last_byte set:
// bit0 MLST/MLSD, bit1 EPSV, bit2 SIZE, bit3 MDTM, bit4 REST STREAM, bit5 UTF8.
// A zero byte ends the reply early; the bytes after it up to the last one
// are ignored.
//
// Each accepted byte lands in an input register and is run through the
// matcher from there, a last byte only once the output register is free;
// the mask of a reply goes from the matcher into the output register that
// drives out_bus. Throughput is one byte per cycle while no last byte waits
// on a stalled output, set by the single matcher update per cycle.
//
// Reset (rst_n low, synchronous) empties both registers and returns the
// matcher to the start of a line with an empty mask. While out_bus is
// stalled, bytes that finish no reply keep flowing; a last byte waits in the
// input register until the output register is free, and in_bus.ready drops.
// ----------------------------------------------------------------------------
module ftp_feature_reply_scanner (
  input  logic       clk,
  input  logic       rst_n,
  ffrs_in_if.sink    in_bus,
  ffrs_out_if.source out_bus
);

  logic              s1_valid_r;
  ffrs_pkg::beat_t   s1_beat_r;
  logic              out_valid_r;
  ffrs_pkg::mask_t   out_mask_r;
  logic              step;
  ffrs_pkg::result_t res;

  // The held byte may proceed unless it would produce a mask into a full,
  // stalled output register.
  assign step = s1_valid_r &&
                (!s1_beat_r.last_byte || !out_valid_r || out_bus.ready);

  assign in_bus.ready      = !s1_valid_r || step;
  assign out_bus.valid     = out_valid_r;
  assign out_bus.caps_mask = out_mask_r;

  ffrs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .beat  (s1_beat_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_beat_r.ch        <= in_bus.ch;
      s1_beat_r.last_byte <= in_bus.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_bus.ready) out_valid_r <= 1'b0;
      if (res.valid) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) out_mask_r <= res.mask;
  end

  a_res_from_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (step && s1_beat_r.last_byte))
    else $error("mask produced by a beat that is not the last of a reply");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |-> !res.valid)
    else $error("pending mask overwritten while output is stalled");

  a_input_reg_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |-> (!s1_valid_r || step))
    else $error("byte accepted while input register still holds a byte");

  a_mask_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> (out_valid_r && $stable(out_mask_r)))
    else $error("stalled mask changed or dropped");

endmodule
